### rtl/vca_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the voice channel allocator.
// No dependencies; vca_alloc, vca_rate and the top level import this package.
package vca_pkg;

  // Fixed field widths of the request and result words.
  localparam int CH_IDX_W = 2;
  localparam int HANDLE_W = 32;
  localparam int HTAG_W   = 30;
  localparam int RATE_W   = 19;
  localparam int SRATE_W  = 16;
  localparam int K_W      = 9;
  localparam int PROD_W   = 25;

  // Reciprocal of 100 scaled by 2^32; exact for dividends below 2^30.
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 32;
  localparam int QUOT_W      = RECIP_SHIFT + RATE_W;
  localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;

  // Lowest pitch step honoured; lower values are clamped.
  localparam logic signed [7:0] PITCH_FLOOR = -8'sd20;

  typedef enum logic [1:0] {
    OP_PLAY    = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_DUP        = 3'd2,
    ST_NO_CHAN    = 3'd3,
    ST_REFUSED    = 3'd4,
    ST_BAD_HANDLE = 3'd5
  } status_t;

  // One request word as held in the input register.
  typedef struct packed {
    opcode_t            opcode;
    logic [15:0]        snd_key;
    logic               source_empty;
    logic signed [2:0]  forced_channel;
    logic signed [7:0]  priority_req;
    logic               dup_drop;
    logic               dup_replace;
    logic [3:0]         playing_mask;
    logic               backend_accepts;
    logic [SRATE_W-1:0] source_rate;
    logic signed [7:0]  pitch;
    logic [HANDLE_W-1:0] handle_in;
  } req_t;

  // Decision of the allocator for one request.
  typedef struct packed {
    status_t              status;
    logic [CH_IDX_W-1:0]  channel;
    logic [HANDLE_W-1:0]  handle_out;
    logic                 stop_request;
    logic [CH_IDX_W-1:0]  stop_index;
  } alloc_res_t;

  // One result word as held in the output register.
  typedef struct packed {
    alloc_res_t         alloc;
    logic [RATE_W-1:0]  effective_rate;
  } out_word_t;

endpackage

### rtl/vca_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result words.
// Depends on nothing; field widths follow the package constants.
interface vca_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] snd_key;
  logic        source_empty;
  logic [2:0]  forced_channel;
  logic [7:0]  priority_req;
  logic        dup_drop;
  logic        dup_replace;
  logic [3:0]  playing_mask;
  logic        backend_accepts;
  logic [15:0] source_rate;
  logic [7:0]  pitch;
  logic [31:0] handle_in;

  modport source (
    output valid, opcode, snd_key, source_empty, forced_channel, priority_req,
           dup_drop, dup_replace, playing_mask, backend_accepts,
           source_rate, pitch, handle_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, snd_key, source_empty, forced_channel, priority_req,
           dup_drop, dup_replace, playing_mask, backend_accepts,
           source_rate, pitch, handle_in,
    output ready
  );
endinterface

interface vca_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  channel;
  logic [31:0] handle_out;
  logic        stop_request;
  logic [1:0]  stop_index;
  logic [18:0] effective_rate;

  modport source (
    output valid, status, channel, handle_out, stop_request, stop_index,
           effective_rate,
    input  ready
  );
  modport sink (
    input  valid, status, channel, handle_out, stop_request, stop_index,
           effective_rate,
    output ready
  );
endinterface

### rtl/vca_alloc.sv
`timescale 1ns / 1ps
// Channel table and allocation decision: priority, identity and tag per
// channel, the running tag counter, and play/resolve/clear handling. Uses vca_pkg.
module vca_alloc import vca_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int TAG_BITS = 30
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  req_t       req,
  output alloc_res_t res
);

  localparam logic [2:0] CH_LIM = 3'(CHANNELS);

  logic signed [7:0]   pri_r [CHANNELS];
  logic [15:0]         snd_r [CHANNELS];
  logic [TAG_BITS-1:0] tag_r [CHANNELS];
  logic [TAG_BITS-1:0] cnt_r;
  logic [TAG_BITS-1:0] cnt_nxt;

  logic [CHANNELS-1:0] play_v, dup_v, free_v, evict_v;
  logic                dup_any, free_any, evict_any;
  logic [CH_IDX_W-1:0] dup_ix, free_ix, evict_ix;
  logic [TAG_BITS-1:0] tag_sel;
  logic                forced_ok, pick_v, commit, clear;
  logic [CH_IDX_W-1:0] pick;

  // Per-channel match vectors and first-set encoders.
  always_comb begin
    play_v   = req.playing_mask[CHANNELS-1:0];
    dup_ix   = '0;
    free_ix  = '0;
    evict_ix = '0;
    tag_sel  = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      dup_v[c]   = play_v[c] && (snd_r[c] == req.snd_key);
      free_v[c]  = !play_v[c];
      evict_v[c] = (pri_r[c] <= req.priority_req);
    end
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (dup_v[c]) dup_ix = CH_IDX_W'(c);
      if (free_v[c]) free_ix = CH_IDX_W'(c);
      if (evict_v[c]) evict_ix = CH_IDX_W'(c);
      if (req.handle_in[CH_IDX_W-1:0] == CH_IDX_W'(c)) tag_sel = tag_r[c];
    end
    dup_any   = |dup_v;
    free_any  = |free_v;
    evict_any = |evict_v;
  end

  assign forced_ok = !req.forced_channel[2] &&
                     ({1'b0, req.forced_channel[1:0]} < CH_LIM);

  // Decision for the request in the input register.
  always_comb begin
    res    = '0;
    pick_v = 1'b0;
    pick   = '0;
    case (req.opcode)
      OP_PLAY: begin
        if (req.source_empty) begin
          res.status = ST_EMPTY;
        end else if (!req.forced_channel[2]) begin
          if (forced_ok) begin
            pick_v = 1'b1;
            pick   = req.forced_channel[1:0];
            if (req.playing_mask[req.forced_channel[1:0]]) begin
              res.stop_request = 1'b1;
              res.stop_index   = req.forced_channel[1:0];
            end
          end else begin
            res.status = ST_NO_CHAN;
          end
        end else if ((req.snd_key != '0) &&
                     (req.dup_drop || req.dup_replace) && dup_any) begin
          if (req.dup_drop) begin
            res.status = ST_DUP;
          end else begin
            pick_v           = 1'b1;
            pick             = dup_ix;
            res.stop_request = 1'b1;
            res.stop_index   = dup_ix;
          end
        end else if (free_any) begin
          pick_v = 1'b1;
          pick   = free_ix;
        end else if (evict_any) begin
          pick_v           = 1'b1;
          pick             = evict_ix;
          res.stop_request = 1'b1;
          res.stop_index   = evict_ix;
        end else begin
          res.status = ST_NO_CHAN;
        end
        if (pick_v) begin
          if (!req.backend_accepts) begin
            res.status = ST_REFUSED;
          end else begin
            res.channel    = pick;
            res.handle_out = {HTAG_W'(cnt_r), pick};
          end
        end
      end
      OP_RESOLVE: begin
        if (({1'b0, req.handle_in[CH_IDX_W-1:0]} >= CH_LIM) ||
            (req.handle_in[HANDLE_W-1:CH_IDX_W] != HTAG_W'(tag_sel))) begin
          res.status = ST_BAD_HANDLE;
        end else begin
          res.channel = req.handle_in[CH_IDX_W-1:0];
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign commit  = fire && (req.opcode == OP_PLAY) && pick_v && req.backend_accepts;
  assign clear   = fire && (req.opcode == OP_CLEAR);
  assign cnt_nxt = cnt_r + TAG_BITS'(1);

  // Table and tag counter update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pri_r[c] <= '0;
        snd_r[c] <= '0;
        tag_r[c] <= '0;
      end
      cnt_r <= TAG_BITS'(1);
    end else if (clear) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pri_r[c] <= '0;
        snd_r[c] <= '0;
        tag_r[c] <= '0;
      end
    end else if (commit) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (pick == CH_IDX_W'(c)) begin
          pri_r[c] <= req.priority_req;
          snd_r[c] <= req.snd_key;
          tag_r[c] <= cnt_r;
        end
      end
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  // The counter advances by one on each committed start and holds otherwise.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (cnt_r == $past(cnt_nxt)))
    else $error("tag counter did not advance on a committed start");
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(cnt_r))
    else $error("tag counter moved without a committed start");
  // A failed request never reports a channel or a handle.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res.status != ST_OK) |-> ((res.channel == '0) && (res.handle_out == '0)))
    else $error("failed request carries a channel or handle");
`endif

endmodule

### rtl/vca_rate.sv
`timescale 1ns / 1ps
// Pitch-scaled sample rate: a registered rate-by-step product, then a
// division by 100 through a reciprocal multiply. Uses vca_pkg.
module vca_rate import vca_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  logic               is_play,
  input  logic [SRATE_W-1:0] source_rate,
  input  logic signed [7:0]  pitch,
  output logic [RATE_W-1:0]  effective_rate
);

  logic signed [7:0]  p_clamp;
  logic [7:0]         p_mag;
  logic [K_W-1:0]     k;
  logic               neg_nxt, neg_r;
  logic [SRATE_W-1:0] base_nxt, base_r;
  logic [PROD_W-1:0]  prod_nxt, prod_r;
  logic [QUOT_W-1:0]  quot_full;
  logic [RATE_W-1:0]  quot;

  // Step factor: three per step upwards, two per step downwards.
  always_comb begin
    p_clamp = (pitch < PITCH_FLOOR) ? PITCH_FLOOR : pitch;
    p_mag   = 8'(-p_clamp);
    if (!is_play) begin
      k = '0;
    end else if (p_clamp > 8'sd0) begin
      k = {2'b00, p_clamp[6:0]} * K_W'(3);
    end else if (p_clamp < 8'sd0) begin
      k = {3'b000, p_mag[4:0], 1'b0};
    end else begin
      k = '0;
    end
    neg_nxt  = is_play && (p_clamp < 8'sd0);
    base_nxt = is_play ? source_rate : '0;
    prod_nxt = {{(PROD_W-SRATE_W){1'b0}}, source_rate} * {{(PROD_W-K_W){1'b0}}, k};
  end

  // Product register.
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
      base_r <= base_nxt;
      neg_r  <= neg_nxt;
    end
  end

  // Division by 100 and the final add or subtract.
  always_comb begin
    quot_full = {{(QUOT_W-PROD_W){1'b0}}, prod_r} *
                {{(QUOT_W-RECIP_W){1'b0}}, RECIP_100};
    quot      = quot_full[QUOT_W-1:RECIP_SHIFT];
    effective_rate = neg_r ? (RATE_W'(base_r) - quot) : (RATE_W'(base_r) + quot);
  end

endmodule

### rtl/voice_channel_allocator.sv
`timescale 1ns / 1ps
// Top level of the voice channel allocator: input register, decision and
// product stage, rate division into the output register. Uses vca_pkg,
// vca_if, vca_alloc and vca_rate.
//
//   Channel  Dir  Handshake     Word
//   in_ch    in   valid/ready   one request (play, resolve or clear)
//   out_ch   out  valid/ready   one result per request
//
// A request passes the input, decision/product and output registers on its
// way to out_ch; one request per cycle is sustained while out_ch is ready.
// The rate multiplies (by step, then by reciprocal of 100) set the stage count.
// Reset is synchronous and active low; it empties the stages and returns the
// channel table to zero and the tag counter to one.
// A stalled out_ch backs up stage by stage; in_ch stays ready while any
// stage has room.
module voice_channel_allocator import vca_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int TAG_BITS = 30
) (
  input  logic  clk,
  input  logic  rst_n,
  vca_in_if.sink    in_ch,
  vca_out_if.source out_ch
);

  localparam logic [2:0] CH_LIM = 3'(CHANNELS);

  logic       in_v_r, mid_v_r, out_v_r;
  logic       adv_mid, adv_out;
  req_t       req_r;
  alloc_res_t res_now, res_mid_r;
  logic [RATE_W-1:0] rate_mid;
  out_word_t  out_r;

  // Stage advance: each stage moves when the next one has room.
  assign adv_out     = mid_v_r && (!out_v_r || out_ch.ready);
  assign adv_mid     = in_v_r && (!mid_v_r || adv_out);
  assign in_ch.ready = !in_v_r || adv_mid;

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_v_r <= in_ch.valid;
      if (!mid_v_r || adv_out) mid_v_r <= adv_mid;
      if (!out_v_r || out_ch.ready) out_v_r <= adv_out;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_r.opcode          <= opcode_t'(in_ch.opcode);
      req_r.snd_key         <= in_ch.snd_key;
      req_r.source_empty    <= in_ch.source_empty;
      req_r.forced_channel  <= in_ch.forced_channel;
      req_r.priority_req    <= in_ch.priority_req;
      req_r.dup_drop        <= in_ch.dup_drop;
      req_r.dup_replace     <= in_ch.dup_replace;
      req_r.playing_mask    <= in_ch.playing_mask;
      req_r.backend_accepts <= in_ch.backend_accepts;
      req_r.source_rate     <= in_ch.source_rate;
      req_r.pitch           <= in_ch.pitch;
      req_r.handle_in       <= in_ch.handle_in;
    end
  end

  vca_alloc #(
    .CHANNELS (CHANNELS),
    .TAG_BITS (TAG_BITS)
  ) u_alloc (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv_mid),
    .req   (req_r),
    .res   (res_now)
  );

  vca_rate u_rate (
    .clk            (clk),
    .load           (adv_mid),
    .is_play        (req_r.opcode == OP_PLAY),
    .source_rate    (req_r.source_rate),
    .pitch          (req_r.pitch),
    .effective_rate (rate_mid)
  );

  // Decision register and output register.
  always_ff @(posedge clk) begin
    if (adv_mid) res_mid_r <= res_now;
    if (adv_out) begin
      out_r.alloc          <= res_mid_r;
      out_r.effective_rate <= rate_mid;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.status         = out_r.alloc.status;
  assign out_ch.channel        = out_r.alloc.channel;
  assign out_ch.handle_out     = out_r.alloc.handle_out;
  assign out_ch.stop_request   = out_r.alloc.stop_request;
  assign out_ch.stop_index     = out_r.alloc.stop_index;
  assign out_ch.effective_rate = out_r.effective_rate;

`ifndef SYNTHESIS
  // Back-pressure reaches the input only when every stage is occupied.
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_v_r && mid_v_r && out_v_r))
    else $error("input stalled with a free stage");
  // A stop always names an existing channel.
  a_stop_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stop_request) |-> ({1'b0, out_ch.stop_index} < CH_LIM))
    else $error("stop names a channel outside the table");
  // A freshly taken decision lands in the output register next cycle.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    adv_out |=> (out_v_r && (out_r.alloc == $past(res_mid_r))))
    else $error("decision not carried to the output register");
`endif

endmodule
